// File: sv/utc_pkg.sv
// shared types, constants and calendar functions for the utc offset adjust block
package utc_pkg;

    // field widths
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int OFFSET_W = 12;
    // minute of day, 0..1439, and signed sum with offset
    localparam int TOD_W    = 11;
    localparam int SUM_W    = 13;

    // calendar and clock constants
    localparam int MIN_PER_DAY   = 1440;
    localparam int MAX_OFFSET    = 1439;
    localparam int MIN_PER_HOUR  = 60;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_MINUTE    = 59;
    localparam int FEB_LEAP_DAYS = 29;

    // month codes
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // one clock reading
    typedef struct packed {
        logic [YEAR_W-1:0]  in_year;
        logic [MONTH_W-1:0] in_month;
        logic [DAY_W-1:0]   in_day;
        logic [HOUR_W-1:0]  in_hour;
        logic [MIN_W-1:0]   in_minute;
        logic [SEC_W-1:0]   in_second;
    } item_t;

    // one local date and time
    typedef struct packed {
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic [HOUR_W-1:0]  out_hour;
        logic [MIN_W-1:0]   out_minute;
        logic [SEC_W-1:0]   out_second;
    } result_t;

    // day roll request from the time of day unit
    typedef struct packed {
        logic back;
        logic fwd;
    } roll_t;

    // gregorian leap rule; divisibility by 25 through a reciprocal multiply
    function automatic logic leap_year(input logic [YEAR_W-1:0] y);
        logic [27:0] prod;
        logic [7:0]  q;
        logic [12:0] back_mul;
        logic        div25;
        prod     = {16'b0, y} * 28'd41944;
        q        = prod[27:20];
        back_mul = {5'b0, q} * 13'd25;
        div25    = (back_mul == {1'b0, y});
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // length of a month, month already clamped to 1..12
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [DAY_W-1:0] d;
        unique case (month)
            MONTH_FEB: d = leap ? DAY_W'(FEB_LEAP_DAYS) : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// File: sv/utc_tod.sv
// time of day unit: adds the offset and splits minute of day into hour and minute
module utc_tod (
    input  logic [utc_pkg::HOUR_W-1:0]          hour,
    input  logic [utc_pkg::MIN_W-1:0]           minute,
    input  logic signed [utc_pkg::OFFSET_W-1:0] offset,
    output logic [utc_pkg::HOUR_W-1:0]          adj_hour,
    output logic [utc_pkg::MIN_W-1:0]           adj_minute,
    output utc_pkg::roll_t                      roll
);

    logic [utc_pkg::HOUR_W-1:0]       hour_c;
    logic [utc_pkg::MIN_W-1:0]        minute_c;
    logic [utc_pkg::TOD_W-1:0]        tod;
    logic signed [utc_pkg::SUM_W-1:0] sum;
    logic signed [utc_pkg::SUM_W-1:0] wrapped;
    logic [utc_pkg::TOD_W-1:0]        t;
    logic [21:0]                      prod;
    logic [utc_pkg::HOUR_W-1:0]       q;
    logic [utc_pkg::TOD_W-1:0]        rem;

    // clamp inputs and form minute of day
    always_comb
    begin
        hour_c   = (hour > utc_pkg::HOUR_W'(utc_pkg::MAX_HOUR))
                   ? utc_pkg::HOUR_W'(utc_pkg::MAX_HOUR) : hour;
        minute_c = (minute > utc_pkg::MIN_W'(utc_pkg::MAX_MINUTE))
                   ? utc_pkg::MIN_W'(utc_pkg::MAX_MINUTE) : minute;
        tod      = utc_pkg::TOD_W'({6'b0, hour_c} * 11'd60) + {5'b0, minute_c};
        sum      = $signed({2'b0, tod}) + utc_pkg::SUM_W'(offset);
    end

    // wrap into the day and flag the roll direction
    always_comb
    begin
        roll.back = (sum < 0);
        roll.fwd  = (sum >= $signed(utc_pkg::SUM_W'(utc_pkg::MIN_PER_DAY)));
        if (roll.back)
        begin
            wrapped = sum + $signed(utc_pkg::SUM_W'(utc_pkg::MIN_PER_DAY));
        end
        else if (roll.fwd)
        begin
            wrapped = sum - $signed(utc_pkg::SUM_W'(utc_pkg::MIN_PER_DAY));
        end
        else
        begin
            wrapped = sum;
        end
        t = wrapped[utc_pkg::TOD_W-1:0];
    end

    // divide by 60 through a reciprocal multiply, exact below 1440
    always_comb
    begin
        prod       = {11'b0, t} * 22'd2185;
        q          = prod[21:17];
        rem        = t - utc_pkg::TOD_W'({6'b0, q} * 11'd60);
        adj_hour   = q;
        adj_minute = rem[utc_pkg::MIN_W-1:0];
    end

endmodule

// File: sv/utc_date.sv
// date unit: clamps the date and moves it one day back or forward
module utc_date (
    input  logic [utc_pkg::YEAR_W-1:0]  year,
    input  logic [utc_pkg::MONTH_W-1:0] month,
    input  logic [utc_pkg::DAY_W-1:0]   day,
    input  utc_pkg::roll_t              roll,
    output logic [utc_pkg::YEAR_W-1:0]  adj_year,
    output logic [utc_pkg::MONTH_W-1:0] adj_month,
    output logic [utc_pkg::DAY_W-1:0]   adj_day
);

    logic                        leap;
    logic [utc_pkg::MONTH_W-1:0] month_c;
    logic [utc_pkg::MONTH_W-1:0] month_prev;
    logic [utc_pkg::DAY_W-1:0]   dim;
    logic [utc_pkg::DAY_W-1:0]   day_c;

    // clamp month and day to the calendar
    always_comb
    begin
        leap = utc_pkg::leap_year(year);
        if (month < utc_pkg::MONTH_JAN)
        begin
            month_c = utc_pkg::MONTH_JAN;
        end
        else if (month > utc_pkg::MONTH_DEC)
        begin
            month_c = utc_pkg::MONTH_DEC;
        end
        else
        begin
            month_c = month;
        end
        month_prev = month_c - 4'd1;
        dim        = utc_pkg::days_in(month_c, leap);
        if (day < 5'd1)
        begin
            day_c = 5'd1;
        end
        else if (day > dim)
        begin
            day_c = dim;
        end
        else
        begin
            day_c = day;
        end
    end

    // one day roll across month and year ends
    always_comb
    begin
        adj_year  = year;
        adj_month = month_c;
        adj_day   = day_c;
        priority if (roll.back)
        begin
            if (day_c > 5'd1)
            begin
                adj_day = day_c - 5'd1;
            end
            else if (month_c == utc_pkg::MONTH_JAN)
            begin
                adj_month = utc_pkg::MONTH_DEC;
                adj_year  = year - 12'd1;
                adj_day   = utc_pkg::days_in(utc_pkg::MONTH_DEC, 1'b0);
            end
            else
            begin
                adj_month = month_prev;
                adj_day   = utc_pkg::days_in(month_prev, leap);
            end
        end
        else if (roll.fwd)
        begin
            if (day_c < dim)
            begin
                adj_day = day_c + 5'd1;
            end
            else
            begin
                adj_day = 5'd1;
                if (month_c == utc_pkg::MONTH_DEC)
                begin
                    adj_month = utc_pkg::MONTH_JAN;
                    adj_year  = year + 12'd1;
                end
                else
                begin
                    adj_month = month_c + 4'd1;
                end
            end
        end
        else
        begin
            adj_day = day_c;
        end
    end

endmodule

// File: sv/utc_offset_date_time_adjust.sv
// top level: local date and time from a clock reading plus a signed minute offset
// Takes one clock reading per item and returns one local date and time per item.
// An item may be taken every cycle; each result appears after its item is taken
// (input register, then result register) as long as results are taken, for a
// throughput of one item per cycle set by the single pass of time of day and
// date logic between the two registers. The offset is written through the cfg
// channel, which is always ready; values beyond +/-1439 minutes are held at the
// limit. Write it only while no item is in flight. Seconds pass through unchanged.
module utc_offset_date_time_adjust (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic signed [utc_pkg::OFFSET_W-1:0] cfg_data,
    input  logic                                item_valid,
    output logic                                item_ready,
    input  utc_pkg::item_t                      item_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output utc_pkg::result_t                    result_data
);

    logic signed [utc_pkg::OFFSET_W-1:0] offset_reg;
    logic signed [utc_pkg::OFFSET_W-1:0] offset_next;
    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    utc_pkg::item_t                      s1_data_reg;
    logic                                res_valid_reg;
    logic                                res_valid_next;
    utc_pkg::result_t                    res_data_reg;
    utc_pkg::result_t                    res_data_next;
    logic                                advance;
    logic                                take;
    utc_pkg::roll_t                      roll;

    // offset register, held at the legal range on write
    assign cfg_ready = 1'b1;
    always_comb
    begin
        offset_next = offset_reg;
        if (cfg_valid)
        begin
            if (cfg_data > $signed(utc_pkg::OFFSET_W'(utc_pkg::MAX_OFFSET)))
            begin
                offset_next = utc_pkg::OFFSET_W'(utc_pkg::MAX_OFFSET);
            end
            else if (cfg_data < -$signed(utc_pkg::OFFSET_W'(utc_pkg::MAX_OFFSET)))
            begin
                offset_next = -$signed(utc_pkg::OFFSET_W'(utc_pkg::MAX_OFFSET));
            end
            else
            begin
                offset_next = cfg_data;
            end
        end
    end

    // pipeline flow control
    assign advance        = !res_valid_reg || result_ready;
    assign item_ready     = !s1_valid_reg || advance;
    assign take           = item_valid && item_ready;
    assign s1_valid_next  = take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign res_valid_next = advance ? s1_valid_reg : res_valid_reg;

    // time of day
    utc_tod u_tod (
        .hour       (s1_data_reg.in_hour),
        .minute     (s1_data_reg.in_minute),
        .offset     (offset_reg),
        .adj_hour   (res_data_next.out_hour),
        .adj_minute (res_data_next.out_minute),
        .roll       (roll)
    );

    // date roll
    utc_date u_date (
        .year      (s1_data_reg.in_year),
        .month     (s1_data_reg.in_month),
        .day       (s1_data_reg.in_day),
        .roll      (roll),
        .adj_year  (res_data_next.out_year),
        .adj_month (res_data_next.out_month),
        .adj_day   (res_data_next.out_day)
    );

    assign res_data_next.out_second = s1_data_reg.in_second;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_data_reg <= item_data;
        end
        if (advance && s1_valid_reg)
        begin
            res_data_reg <= res_data_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_data_reg;

endmodule

// File: sv/utc_checker.sv
// port level checks for the utc offset adjust block, with bind
module utc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             item_valid,
    input logic             item_ready,
    input utc_pkg::item_t   item_data,
    input logic             result_valid,
    input logic             result_ready,
    input utc_pkg::result_t result_data
);

    // a waiting result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // a free result side never blocks the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> item_ready)
        else $error("input stalled with result side free");

    // an item followed by a free result side shows up in the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready ##1 result_ready |=> result_valid)
        else $error("result missing after item");

    // the second passes through with its item
    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready ##1 result_ready
        |=> result_data.out_second == $past(item_data.in_second, 2))
        else $error("second not passed through");

endmodule

bind utc_offset_date_time_adjust utc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);

// File: bench/tb_utc_offset_date_time_adjust.sv
// testbench for the utc offset date and time adjust block, with a scoreboard class
`timescale 1ns / 100ps

module tb_utc_offset_date_time_adjust;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 105;
    localparam int NUM_PHASES  = 12;

    // expected local time queue and field checks
    class date_scoreboard;
        utc_pkg::result_t                     pending[$];
        int                                   errors;
        logic signed [utc_pkg::OFFSET_W-1:0]  offset;
        int                                   month_len[12] = '{31, 28, 31, 30, 31, 30,
                                                                31, 31, 30, 31, 30, 31};

        function bit is_leap(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_days(int m, int y);
            if (m == 2 && is_leap(y))
                return utc_pkg::FEB_LEAP_DAYS;
            return month_len[m - 1];
        endfunction

        // calendar arithmetic for one clock reading
        function utc_pkg::result_t local_time(utc_pkg::item_t rd);
            int               yr;
            int               mo;
            int               dy;
            int               hr;
            int               mi;
            int               off;
            int               dim;
            int               total;
            utc_pkg::result_t r;
            yr  = rd.in_year;
            mo  = rd.in_month;
            dy  = rd.in_day;
            hr  = rd.in_hour;
            mi  = rd.in_minute;
            off = int'(offset);
            // clamp offset and fields into range
            if (off > utc_pkg::MAX_OFFSET)
                off = utc_pkg::MAX_OFFSET;
            if (off < -utc_pkg::MAX_OFFSET)
                off = -utc_pkg::MAX_OFFSET;
            if (hr > utc_pkg::MAX_HOUR)
                hr = utc_pkg::MAX_HOUR;
            if (mi > utc_pkg::MAX_MINUTE)
                mi = utc_pkg::MAX_MINUTE;
            if (mo < 1)
                mo = 1;
            if (mo > 12)
                mo = 12;
            dim = month_days(mo, yr);
            if (dy < 1)
                dy = 1;
            if (dy > dim)
                dy = dim;
            total = hr * utc_pkg::MIN_PER_HOUR + mi + off;
            // roll the date back or forward by one day
            if (total < 0) begin
                total += utc_pkg::MIN_PER_DAY;
                if (dy > 1)
                    dy--;
                else begin
                    if (mo == 1) begin
                        mo = 12;
                        yr = (yr - 1) & 'hFFF;
                    end
                    else
                        mo--;
                    dy = month_days(mo, yr);
                end
            end
            else if (total >= utc_pkg::MIN_PER_DAY) begin
                total -= utc_pkg::MIN_PER_DAY;
                if (dy < dim)
                    dy++;
                else begin
                    dy = 1;
                    if (mo == 12) begin
                        mo = 1;
                        yr = (yr + 1) & 'hFFF;
                    end
                    else
                        mo++;
                end
            end
            r.out_year   = utc_pkg::YEAR_W'(yr);
            r.out_month  = utc_pkg::MONTH_W'(mo);
            r.out_day    = utc_pkg::DAY_W'(dy);
            r.out_hour   = utc_pkg::HOUR_W'(total / utc_pkg::MIN_PER_HOUR);
            r.out_minute = utc_pkg::MIN_W'(total % utc_pkg::MIN_PER_HOUR);
            r.out_second = rd.in_second;
            return r;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_reading(utc_pkg::item_t rd);
            pending.push_back(local_time(rd));
        endfunction

        task check_result(utc_pkg::result_t got);
            utc_pkg::result_t exp;
            if (pending.size() == 0) begin
                report("result with no item outstanding");
                return;
            end
            exp = pending.pop_front();
            if (got.out_year !== exp.out_year)
                report($sformatf("year %0d, expected %0d", got.out_year, exp.out_year));
            if (got.out_month !== exp.out_month)
                report($sformatf("month %0d, expected %0d", got.out_month, exp.out_month));
            if (got.out_day !== exp.out_day)
                report($sformatf("day %0d, expected %0d", got.out_day, exp.out_day));
            if (got.out_hour !== exp.out_hour)
                report($sformatf("hour %0d, expected %0d", got.out_hour, exp.out_hour));
            if (got.out_minute !== exp.out_minute)
                report($sformatf("minute %0d, expected %0d",
                                 got.out_minute, exp.out_minute));
            if (got.out_second !== exp.out_second)
                report($sformatf("second %0d, expected %0d",
                                 got.out_second, exp.out_second));
        endtask
    endclass

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic signed [utc_pkg::OFFSET_W-1:0] cfg_data;
    logic                                item_valid;
    logic                                item_ready;
    utc_pkg::item_t                      item_data;
    logic                                result_valid;
    logic                                result_ready;
    utc_pkg::result_t                    result_data;

    date_scoreboard sb;
    bit             steady;
    bit             hold_request;
    int             quiet_cycles;

    utc_offset_date_time_adjust u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 38);
    endfunction

    function automatic utc_pkg::item_t mk(int y, int m, int d, int h, int mi, int s);
        utc_pkg::item_t rd;
        rd.in_year   = utc_pkg::YEAR_W'(y);
        rd.in_month  = utc_pkg::MONTH_W'(m);
        rd.in_day    = utc_pkg::DAY_W'(d);
        rd.in_hour   = utc_pkg::HOUR_W'(h);
        rd.in_minute = utc_pkg::MIN_W'(mi);
        rd.in_second = utc_pkg::SEC_W'(s);
        return rd;
    endfunction

    // mostly valid readings biased to day, month and year edges; some raw noise
    function automatic utc_pkg::item_t random_reading();
        utc_pkg::item_t rd;
        logic [63:0]    raw;
        int             y;
        int             m;
        int             d;
        int             h;
        int             mi;
        int             pick;
        int             specials[4] = '{1900, 2000, 2100, 2400};
        raw = {$urandom, $urandom};
        rd  = raw[$bits(utc_pkg::item_t)-1:0];
        if ($urandom_range(99) < 85) begin
            pick = $urandom_range(99);
            if (pick < 70)
                y = $urandom_range(2099, 2000);
            else if (pick < 80)
                y = specials[$urandom_range(3)];
            else
                y = $urandom_range(4095);
            m = $urandom_range(12, 1);
            pick = $urandom_range(99);
            if (pick < 20)
                d = 1;
            else if (pick < 40)
                d = sb.month_days(m, y);
            else
                d = $urandom_range(sb.month_days(m, y), 1);
            pick = $urandom_range(99);
            h  = (pick < 20) ? 0 : (pick < 40) ? utc_pkg::MAX_HOUR
                                               : $urandom_range(utc_pkg::MAX_HOUR);
            pick = $urandom_range(99);
            mi = (pick < 20) ? 0 : (pick < 40) ? utc_pkg::MAX_MINUTE
                                               : $urandom_range(utc_pkg::MAX_MINUTE);
            rd = mk(y, m, d, h, mi, $urandom_range(63));
        end
        return rd;
    endfunction

    // offer one reading and wait for it to be taken
    task send_reading(utc_pkg::item_t rd);
        while (take_break()) begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= rd;
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        @(posedge clk);
        sb.note_reading(rd);
    endtask

    task drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task set_offset(logic signed [utc_pkg::OFFSET_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        sb.offset = value;
    endtask

    // result side: random stalls plus one long hold-off
    initial
    begin
        utc_pkg::result_t got;
        bit               take;
        int               hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= !take_break();
            @(negedge clk);
            take = result_valid && result_ready;
            got  = result_data;
            @(posedge clk);
            if (take)
                sb.check_result(got);
        end
    end

    // watchdog on cycles with no handshake
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        utc_pkg::item_t                       dir_zero[7];
        utc_pkg::item_t                       dir_fwd[7];
        utc_pkg::item_t                       dir_back[7];
        logic signed [utc_pkg::OFFSET_W-1:0]  phase_offset[NUM_PHASES];
        sb = new();
        sb.errors    = 0;
        sb.offset    = '0;
        steady       = 1'b0;
        hold_request = 1'b0;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        item_valid   <= 1'b0;
        item_data    <= '0;
        result_ready <= 1'b0;

        // clamping and plain cases at reset offset
        dir_zero = '{mk(2024, 2, 29, 12, 30, 15), mk(2023, 2, 31, 10, 0, 0),
                     mk(2024, 4, 0, 0, 0, 0), mk(2024, 0, 15, 5, 5, 5),
                     mk(2024, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0),
                     mk(4095, 15, 31, 31, 63, 63)};
        // forward rolls: year wrap, century and leap februaries, month end
        dir_fwd  = '{mk(4095, 12, 31, 23, 59, 59), mk(2100, 2, 28, 1, 0, 0),
                     mk(2000, 2, 28, 1, 0, 0), mk(2024, 2, 29, 0, 1, 0),
                     mk(2023, 4, 30, 12, 0, 0), mk(2023, 6, 15, 0, 0, 30),
                     mk(2023, 2, 30, 1, 0, 0)};
        // backward rolls: year zero wrap, march into february, month start
        dir_back = '{mk(0, 1, 1, 0, 0, 0), mk(2100, 3, 1, 0, 0, 0),
                     mk(2000, 3, 1, 0, 0, 0), mk(2024, 1, 1, 23, 59, 0),
                     mk(2023, 5, 1, 10, 0, 0), mk(2023, 8, 0, 0, 0, 0),
                     mk(1900, 3, 1, 0, 0, 0)};
        phase_offset = '{12'sd2047, -12'sd2048, 12'sd1440, -12'sd1440, 12'sd1, -12'sd1,
                         12'sd720, -12'sd720, 12'sd0, 12'sd0, 12'sd0, 12'sd0};
        phase_offset[8]  = utc_pkg::OFFSET_W'($urandom_range(4095));
        phase_offset[9]  = utc_pkg::OFFSET_W'($urandom_range(2 * utc_pkg::MAX_OFFSET)
                                              - utc_pkg::MAX_OFFSET);
        phase_offset[10] = utc_pkg::OFFSET_W'($urandom_range(2 * utc_pkg::MAX_OFFSET)
                                              - utc_pkg::MAX_OFFSET);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        foreach (dir_zero[i])
            send_reading(dir_zero[i]);
        item_valid <= 1'b0;
        drain();
        set_offset(12'(utc_pkg::MAX_OFFSET));
        foreach (dir_fwd[i])
            send_reading(dir_fwd[i]);
        item_valid <= 1'b0;
        drain();
        set_offset(-12'(utc_pkg::MAX_OFFSET));
        foreach (dir_back[i])
            send_reading(dir_back[i]);
        item_valid <= 1'b0;
        drain();

        // random phases, one without idling and with the receiver held off
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_offset(phase_offset[p]);
            steady = (p == 2);
            if (p == 2)
                hold_request = 1'b1;
            repeat (PHASE_ITEMS)
                send_reading(random_reading());
            item_valid <= 1'b0;
            drain();
        end
        steady = 1'b0;

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: utc_offset_date_time_adjust.f
sv/utc_pkg.sv
sv/utc_tod.sv
sv/utc_date.sv
sv/utc_offset_date_time_adjust.sv
sv/utc_checker.sv
bench/tb_utc_offset_date_time_adjust.sv
